>>> hw/rtl/satc_pkg.sv
// types, constants and codes for the set-associative translation cache
// no dependencies; used by satc_ram users and the top level
package satc_pkg;

  localparam int unsigned DefaultWays = 4;
  localparam int unsigned NumSets     = 16;
  localparam int unsigned NumHalves   = 2;
  localparam int unsigned NumRows     = NumHalves * NumSets;
  localparam int unsigned SetW        = $clog2(NumSets);
  localparam int unsigned RowW        = $clog2(NumRows);
  localparam int unsigned TagW        = 17;
  localparam int unsigned PhysW       = 32;
  localparam int unsigned StatusW     = 16;
  localparam int unsigned AddrW       = 32;
  localparam int unsigned GlobalBit   = 10;

  // apb register map
  localparam int unsigned ApbAddrW    = 3;
  localparam int unsigned ApbDataW    = 32;
  localparam logic        RegPage8k   = 1'b0;

  typedef enum logic [1:0] {
    OpLookup    = 2'd0,
    OpStore     = 2'd1,
    OpFlushPage = 2'd2,
    OpFlushAll  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    StIdle,
    StExec,
    StFlushLo,
    StFlushHi,
    StFlushAll
  } state_e;

  typedef struct packed {
    op_e                 func;
    logic                access_kind;
    logic [AddrW-1:0]    address;
    logic                supervisor;
    logic [PhysW-1:0]    phys_addr;
    logic [StatusW-1:0]  entry_status;
    logic                include_global;
  } req_t;

  typedef struct packed {
    logic                hit;
    logic [1:0]          hit_way;
    logic [PhysW-1:0]    read_phys;
    logic [StatusW-1:0]  read_status;
  } rsp_t;

  typedef struct packed {
    logic [TagW-1:0]     tag;
    logic [PhysW-1:0]    phys;
    logic [StatusW-1:0]  status;
  } entry_t;

endpackage

>>> hw/rtl/set_assoc_translation_cache_unit.sv
// set-associative translation cache, data and instruction halves, round-robin refill
// depends on satc_pkg and satc_ram (one ram per way, one row per half and set)
// lookup and store: request taken, way rams read, result strobed from the exec state;
// busy holds off new requests until then. flush page: one ram read per half; flush all:
// one ram row read per cycle over all 32 rows. the result strobe cannot be stalled
// reset clears valid bits, replacement pointers, page size and the fsm; ram needs none
module set_assoc_translation_cache_unit #(
  parameter int unsigned Ways = satc_pkg::DefaultWays
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request side
  input  logic                            start,
  output logic                            busy,
  input  satc_pkg::req_t                  req_i,
  // result side, one cycle strobe
  output logic                            rsp_valid_o,
  output satc_pkg::rsp_t                  rsp_o,
  // apb configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [satc_pkg::ApbAddrW-1:0]   paddr,
  input  logic [satc_pkg::ApbDataW-1:0]   pwdata,
  output logic [satc_pkg::ApbDataW-1:0]   prdata,
  output logic                            pready
);
  import satc_pkg::*;

  localparam int unsigned WayW = $clog2(Ways);

  // ---------------------------------------------------------------------------
  // configuration register: page size select at byte address 0
  // ---------------------------------------------------------------------------
  logic page_8k_q, page_8k_d;
  logic apb_wr;

  assign pready = 1'b1;
  assign apb_wr = psel && penable && pwrite;

  always_comb begin
    page_8k_d = page_8k_q;
    if (apb_wr && (paddr[ApbAddrW-1] == RegPage8k)) begin
      page_8k_d = pwdata[0];
    end
  end

  assign prdata = (paddr[ApbAddrW-1] == RegPage8k) ?
                  {{(ApbDataW-1){1'b0}}, page_8k_q} : '0;

  // ---------------------------------------------------------------------------
  // index and tag from the incoming request
  // tag is {supervisor, address[31:17], address[16]} with the low bit masked in 8k mode
  // ---------------------------------------------------------------------------
  logic [SetW-1:0] in_set;
  logic [TagW-1:0] in_tag;
  logic [RowW-1:0] in_row;

  assign in_set = page_8k_q ? req_i.address[16:13] : req_i.address[15:12];
  assign in_tag = {req_i.supervisor, req_i.address[31:17],
                   req_i.address[16] & ~page_8k_q};

  always_comb begin
    case (req_i.func)
      OpLookup, OpStore: in_row = {req_i.access_kind, in_set};
      OpFlushPage:       in_row = {1'b0, in_set};
      OpFlushAll:        in_row = '0;
      default:           in_row = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // state: fsm, captured request, current row, valid bits and pointers in flops
  // ---------------------------------------------------------------------------
  state_e          state_q, state_d;
  req_t            req_q, req_d;
  logic [TagW-1:0] tag_q, tag_d;
  logic [RowW-1:0] row_q, row_d;
  logic [Ways-1:0] valid_q [NumRows];
  logic [Ways-1:0] valid_d [NumRows];
  logic [WayW-1:0] ptr_q   [NumRows];
  logic [WayW-1:0] ptr_d   [NumRows];
  rsp_t            rsp_q, rsp_d;
  logic            rsp_valid_q, rsp_valid_d;

  logic            accept;
  assign busy   = (state_q != StIdle);
  assign accept = start && !busy;

  // ---------------------------------------------------------------------------
  // way memories: one row per half and set, read in the cycle before their use
  // ---------------------------------------------------------------------------
  entry_t          rd_entry [Ways];
  entry_t          wr_entry;
  logic [RowW-1:0] ram_raddr;
  logic [Ways-1:0] ram_we;

  assign wr_entry = '{tag: tag_q, phys: req_q.phys_addr, status: req_q.entry_status};

  for (genvar g = 0; g < Ways; g++) begin : g_way
    satc_ram #(
      .Width ($bits(entry_t)),
      .Depth (NumRows)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we[g]),
      .waddr_i (row_q),
      .wdata_i (wr_entry),
      .raddr_i (ram_raddr),
      .rdata_o (rd_entry[g])
    );
  end

  // read address: the request's row when idle, then the next row of a sweep
  always_comb begin
    case (state_q)
      StIdle:     ram_raddr = in_row;
      StFlushLo:  ram_raddr = {1'b1, row_q[SetW-1:0]};
      StFlushAll: ram_raddr = row_q + RowW'(1);
      default:    ram_raddr = row_q;
    endcase
  end

  // ---------------------------------------------------------------------------
  // per-way compare against the row just read
  // ---------------------------------------------------------------------------
  logic [Ways-1:0] tag_match;
  logic [Ways-1:0] is_global;

  always_comb begin
    for (int w = 0; w < Ways; w++) begin
      tag_match[w] = valid_q[row_q][w] && (rd_entry[w].tag == tag_q);
      is_global[w] = rd_entry[w].status[GlobalBit];
    end
  end

  // lowest matching way for lookup
  logic            lk_hit;
  logic [1:0]      lk_way;
  entry_t          lk_entry;

  always_comb begin
    lk_hit   = 1'b0;
    lk_way   = '0;
    lk_entry = '0;
    for (int w = 0; w < Ways; w++) begin
      if (!lk_hit && tag_match[w]) begin
        lk_hit   = 1'b1;
        lk_way   = 2'(w);
        lk_entry = rd_entry[w];
      end
    end
  end

  // store victim: lowest free way, else the round-robin pointer
  logic            st_free;
  logic [WayW-1:0] st_way;
  logic [WayW-1:0] cur_ptr;

  assign cur_ptr = ptr_q[row_q];

  always_comb begin
    st_free = 1'b0;
    st_way  = cur_ptr;
    for (int w = 0; w < Ways; w++) begin
      if (!st_free && !valid_q[row_q][w]) begin
        st_free = 1'b1;
        st_way  = WayW'(w);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // next state and updates
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    tag_d       = tag_q;
    row_d       = row_q;
    valid_d     = valid_q;
    ptr_d       = ptr_q;
    rsp_d       = '0;
    rsp_valid_d = 1'b0;
    ram_we      = '0;

    case (state_q)
      StIdle: begin
        if (accept) begin
          req_d = req_i;
          tag_d = in_tag;
          row_d = in_row;
          case (req_i.func)
            OpLookup, OpStore: state_d = StExec;
            OpFlushPage:       state_d = StFlushLo;
            OpFlushAll:        state_d = StFlushAll;
            default:           state_d = StExec;
          endcase
        end
      end

      StExec: begin
        rsp_valid_d = 1'b1;
        if (req_q.func == OpLookup) begin
          rsp_d.hit         = lk_hit;
          rsp_d.hit_way     = lk_way;
          rsp_d.read_phys   = lk_entry.phys;
          rsp_d.read_status = lk_entry.status;
        end else begin
          ram_we[st_way]          = 1'b1;
          valid_d[row_q][st_way]  = 1'b1;
          if (!st_free) begin
            ptr_d[row_q] = (cur_ptr == WayW'(Ways - 1)) ? '0 : cur_ptr + WayW'(1);
          end
        end
        state_d = StIdle;
      end

      // flush page: data half first, then instruction half of the same set
      StFlushLo, StFlushHi: begin
        for (int w = 0; w < Ways; w++) begin
          if (tag_match[w] && (req_q.include_global || !is_global[w])) begin
            valid_d[row_q][w] = 1'b0;
          end
        end
        if (state_q == StFlushLo) begin
          row_d   = {1'b1, row_q[SetW-1:0]};
          state_d = StFlushHi;
        end else begin
          rsp_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end

      // flush all: sweep every row, keeping global entries unless asked
      StFlushAll: begin
        for (int w = 0; w < Ways; w++) begin
          if (req_q.include_global || !is_global[w]) begin
            valid_d[row_q][w] = 1'b0;
          end
        end
        row_d = row_q + RowW'(1);
        if (row_q == RowW'(NumRows - 1)) begin
          rsp_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      page_8k_q   <= 1'b0;
      rsp_valid_q <= 1'b0;
      row_q       <= '0;
      for (int r = 0; r < NumRows; r++) begin
        valid_q[r] <= '0;
        ptr_q[r]   <= '0;
      end
    end else begin
      state_q     <= state_d;
      page_8k_q   <= page_8k_d;
      rsp_valid_q <= rsp_valid_d;
      row_q       <= row_d;
      valid_q     <= valid_d;
      ptr_q       <= ptr_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    tag_q <= tag_d;
    rsp_q <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

>>> hw/rtl/satc_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module satc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> tb/set_assoc_translation_cache_unit_tb.sv
// self-checking testbench for the set-associative translation cache unit
// needs satc_pkg and the unit rtl; predicts every result with its own cache image
module set_assoc_translation_cache_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import satc_pkg::*;

  localparam int unsigned Ways        = DefaultWays;
  localparam int unsigned QuietLimit  = 2000;   // cycles with no request, result or apb access
  localparam int unsigned DrainEvery  = 150;    // requests between forced drains
  localparam int unsigned GapPercent  = 34;
  localparam int unsigned PoolSize    = 48;
  localparam int unsigned MaxReports  = 40;
  localparam int unsigned RegIdxPage8k = 0;

  localparam logic [31:0] SupFlag   = 32'h8000_0000;
  localparam logic [31:0] TagMask4k = 32'hFFFF_8000;
  localparam logic [31:0] TagMask8k = 32'hFFFF_0000;
  localparam logic        HalfData  = 1'b0;
  localparam logic        HalfInstr = 1'b1;

  // clock, reset and dut signals; the driven ones are known from time zero
  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                start     = 1'b0;
  logic                busy;
  req_t                req       = '0;
  logic                rsp_valid;
  rsp_t                rsp;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [ApbAddrW-1:0] paddr     = '0;
  logic [ApbDataW-1:0] pwdata    = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  // request and result bookkeeping
  req_t        pending_reqs[$];
  rsp_t        expected_rsps[$];
  int unsigned issued_count = 0;
  int unsigned checked_count = 0;
  int unsigned n_errors = 0;
  int unsigned n_lookups = 0, n_hits = 0, n_stores = 0, n_page_flushes = 0, n_full_flushes = 0;
  int unsigned n_reg_writes = 0;
  int unsigned quiet_cycles = 0;
  bit          no_idle = 1'b0;

  // cache image kept by the testbench: valid bits, contents, refill pointers, page size
  bit              ent_valid  [NumHalves][NumSets][Ways];
  logic [TagW-1:0] ent_tag    [NumHalves][NumSets][Ways];
  logic [PhysW-1:0] ent_phys  [NumHalves][NumSets][Ways];
  logic [StatusW-1:0] ent_status [NumHalves][NumSets][Ways];
  int unsigned     rr_ptr     [NumHalves][NumSets];
  bit              page_8k_q = 1'b0;

  // address pool: few sets and tags so that hits, refills and flushes really happen
  logic [AddrW-1:0] page_pool [PoolSize];
  bit               pool_sup  [PoolSize];

  set_assoc_translation_cache_unit #(
    .Ways(Ways)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req),
    .rsp_valid_o(rsp_valid),
    .rsp_o      (rsp),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // works out the result of one request and updates the cache image as the unit should
  function automatic rsp_t predict_translation(req_t r);
    rsp_t             o;
    int unsigned      s, h, hh, w, way;
    logic [31:0]      full_tag;
    logic [TagW-1:0]  t;
    bit               found;
    o = '0;
    found = 1'b0;
    // set index and tag follow the page size in force now
    s = page_8k_q ? r.address[16:13] : r.address[15:12];
    full_tag = ((r.supervisor ? SupFlag : 32'h0) | (r.address >> 1))
               & (page_8k_q ? TagMask8k : TagMask4k);
    t = full_tag[31:15];
    h = r.access_kind;
    case (r.func)
      OpLookup: begin
        n_lookups++;
        // lowest matching way wins
        for (w = 0; w < Ways; w++) begin
          if (!found && ent_valid[h][s][w] && ent_tag[h][s][w] == t) begin
            found = 1'b1;
            o.hit = 1'b1;
            o.hit_way = 2'(w);
            o.read_phys = ent_phys[h][s][w];
            o.read_status = ent_status[h][s][w];
          end
        end
        if (found) n_hits++;
      end
      OpStore: begin
        n_stores++;
        // first free way, else the round-robin victim
        way = Ways;
        for (w = 0; w < Ways; w++) begin
          if (way == Ways && !ent_valid[h][s][w]) way = w;
        end
        if (way == Ways) begin
          way = rr_ptr[h][s];
          rr_ptr[h][s] = (way + 1 == Ways) ? 0 : way + 1;
        end
        ent_valid[h][s][way]  = 1'b1;
        ent_tag[h][s][way]    = t;
        ent_phys[h][s][way]   = r.phys_addr;
        ent_status[h][s][way] = r.entry_status;
      end
      OpFlushPage: begin
        n_page_flushes++;
        // both halves, global entries spared unless asked
        for (hh = 0; hh < NumHalves; hh++) begin
          for (w = 0; w < Ways; w++) begin
            if (ent_valid[hh][s][w] && ent_tag[hh][s][w] == t
                && (r.include_global || !ent_status[hh][s][w][GlobalBit]))
              ent_valid[hh][s][w] = 1'b0;
          end
        end
      end
      default: begin
        n_full_flushes++;
        for (hh = 0; hh < NumHalves; hh++) begin
          for (s = 0; s < NumSets; s++) begin
            for (w = 0; w < Ways; w++) begin
              if (r.include_global || !ent_status[hh][s][w][GlobalBit])
                ent_valid[hh][s][w] = 1'b0;
            end
          end
        end
      end
    endcase
    return o;
  endfunction

  function automatic req_t make_request(op_e op, logic half, logic [AddrW-1:0] addr,
                                        logic sup, logic [PhysW-1:0] phys,
                                        logic [StatusW-1:0] status, logic incl);
    req_t r;
    r.func           = op;
    r.access_kind    = half;
    r.address        = addr;
    r.supervisor     = sup;
    r.phys_addr      = phys;
    r.entry_status   = status;
    r.include_global = incl;
    return r;
  endfunction

  // mostly pool addresses with random page offset, some fully random ones
  function automatic req_t random_request();
    req_t        r;
    int unsigned pick, sel;
    pick = $urandom_range(99);
    r.func = (pick < 48) ? OpLookup : (pick < 82) ? OpStore :
             (pick < 96) ? OpFlushPage : OpFlushAll;
    r.access_kind = 1'($urandom_range(1));
    if ($urandom_range(9) < 8) begin
      sel = $urandom_range(PoolSize - 1);
      r.address = page_pool[sel] | 32'($urandom_range(4095));
      r.supervisor = pool_sup[sel] ^ ($urandom_range(9) == 0);
    end else begin
      r.address = $urandom;
      r.supervisor = 1'($urandom_range(1));
    end
    r.phys_addr = $urandom;
    r.entry_status = 16'($urandom);
    r.include_global = ($urandom_range(3) == 0);
    return r;
  endfunction

  // request driver: offers the next pending request, with random gaps and periodic drains
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      req <= '0;
    end else begin
      if (start && !busy) begin
        expected_rsps.push_back(predict_translation(req));
        issued_count++;
      end
      // slot is free when nothing is offered or the offer was just taken
      if (!start || !busy) begin
        if (pending_reqs.size() != 0 && (no_idle || $urandom_range(99) >= GapPercent)
            && !(issued_count % DrainEvery == 0 && expected_rsps.size() != 0)) begin
          start <= 1'b1;
          req <= pending_reqs.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      n_errors++;
      if (n_errors <= MaxReports)
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endtask

  // result monitor: strobed results are compared in order with the oldest expectation
  always @(posedge clk_i) begin : result_check
    rsp_t want;
    if (rst_ni && rsp_valid) begin
      if (expected_rsps.size() == 0) begin
        n_errors++;
        if (n_errors <= MaxReports)
          $display("%0t: unexpected result, expected none actual %p", $time, rsp);
      end else begin
        want = expected_rsps.pop_front();
        checked_count++;
        check_field("hit", 32'(want.hit), 32'(rsp.hit));
        check_field("hit_way", 32'(want.hit_way), 32'(rsp.hit_way));
        check_field("read_phys", want.read_phys, rsp.read_phys);
        check_field("read_status", 32'(want.read_status), 32'(rsp.read_status));
      end
    end
  end

  // watchdog on cycles where nothing moves
  always @(posedge clk_i) begin
    if ((start && !busy) || rsp_valid || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no progress for %0d cycles", $time, QuietLimit);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // apb write of the page size register, then read it back
  task automatic set_page_size(bit big);
    logic [ApbAddrW-1:0] a;
    a = ApbAddrW'(4 * RegIdxPage8k);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= 32'(big);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    page_8k_q = big;
    n_reg_writes++;
    @(posedge clk_i);
    psel <= 1'b1; paddr <= a;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field("page_8k readback", 32'(big), prdata);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  // unit idle: nothing pending, nothing outstanding, nothing offered
  // checked at the falling edge, once the driver and monitor updates have settled
  task automatic wait_idle();
    @(negedge clk_i);
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || start || busy)
      @(negedge clk_i);
  endtask

  initial begin : stimulus
    bit          phase_page [4];
    int unsigned phase_len  [4];
    int unsigned i, p, k;
    phase_page = '{1'b1, 1'b0, 1'b1, 1'b0};
    phase_len  = '{300, 300, 300, 350};

    // pool: set bits 12..14 random, 15..16 clear, random tag bits above
    for (i = 0; i < PoolSize; i++) begin
      page_pool[i] = ($urandom & 32'hFFFE_0000) | (32'($urandom_range(7)) << 12);
      pool_sup[i] = 1'($urandom_range(1));
    end

    // reset once, valid bits and refill pointers start cleared in the image too
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part in 4K page mode
    set_page_size(1'b0);
    // miss on an empty cache, then a global entry with all-ones contents
    pending_reqs.push_back(make_request(OpLookup, HalfData, 32'h0, 1'b0, '0, '0, 1'b0));
    pending_reqs.push_back(make_request(OpStore, HalfData, 32'h0000_3ABC, 1'b0,
                                        32'hFFFF_FFFF, 16'hFFFF, 1'b0));
    pending_reqs.push_back(make_request(OpLookup, HalfData, 32'h0000_3000, 1'b0, '0, '0, 1'b0));
    // supervisor flag is part of the tag
    pending_reqs.push_back(make_request(OpLookup, HalfData, 32'h0000_3000, 1'b1, '0, '0, 1'b0));
    // instruction half, all-ones address, zero contents
    pending_reqs.push_back(make_request(OpStore, HalfInstr, 32'hFFFF_FFFF, 1'b1, '0, '0, 1'b0));
    pending_reqs.push_back(make_request(OpLookup, HalfInstr, 32'hFFFF_F000, 1'b1, '0, '0, 1'b0));
    // five stores into one set: fills the free ways then evicts by round robin
    for (k = 1; k <= 5; k++)
      pending_reqs.push_back(make_request(OpStore, HalfData, (k << 16) | 32'h5000, 1'b0,
                                          32'h1111_1111 * k, 16'(k), 1'b0));
    pending_reqs.push_back(make_request(OpLookup, HalfData, 32'h0001_5000, 1'b0, '0, '0, 1'b0));
    pending_reqs.push_back(make_request(OpLookup, HalfData, 32'h0005_5000, 1'b0, '0, '0, 1'b0));
    // same page stored twice: lookup must report the lower way
    pending_reqs.push_back(make_request(OpStore, HalfData, 32'h0000_9000, 1'b0,
                                        32'hAAAA_0000, '0, 1'b0));
    pending_reqs.push_back(make_request(OpStore, HalfData, 32'h0000_9000, 1'b0,
                                        32'h5555_0000, '0, 1'b0));
    pending_reqs.push_back(make_request(OpLookup, HalfData, 32'h0000_9000, 1'b0, '0, '0, 1'b0));
    // flush all sparing global entries, then page flushes without and with globals
    pending_reqs.push_back(make_request(OpFlushAll, HalfData, '0, 1'b0, '0, '0, 1'b0));
    pending_reqs.push_back(make_request(OpLookup, HalfData, 32'h0000_3000, 1'b0, '0, '0, 1'b0));
    pending_reqs.push_back(make_request(OpFlushPage, HalfInstr, 32'h0000_3000, 1'b0,
                                        '0, '0, 1'b0));
    pending_reqs.push_back(make_request(OpFlushPage, HalfInstr, 32'h0000_3FFF, 1'b0,
                                        '0, '0, 1'b1));
    pending_reqs.push_back(make_request(OpLookup, HalfData, 32'h0000_3000, 1'b0, '0, '0, 1'b0));
    // global entry dropped by a flush all that includes globals
    pending_reqs.push_back(make_request(OpStore, HalfInstr, 32'h1234_5000, 1'b0,
                                        32'hCAFE_0000, 16'h0400, 1'b0));
    pending_reqs.push_back(make_request(OpFlushAll, HalfInstr, '0, 1'b0, '0, '0, 1'b1));
    pending_reqs.push_back(make_request(OpLookup, HalfInstr, 32'h1234_5000, 1'b0,
                                        '0, '0, 1'b0));

    // random phases, page size switched while entries stay valid; third phase has no random gaps
    for (p = 0; p < 4; p++) begin
      wait_idle();
      set_page_size(phase_page[p]);
      no_idle = (p == 2);
      for (i = 0; i < phase_len[p]; i++)
        pending_reqs.push_back(random_request());
    end

    wait_idle();
    repeat (40) @(posedge clk_i);

    $display("covered %0d requests: %0d lookups (%0d hits), %0d stores, %0d page flushes,",
             issued_count, n_lookups, n_hits, n_stores, n_page_flushes);
    $display("%0d full flushes, %0d results checked, %0d page size writes over 4K and 8K",
             n_full_flushes, checked_count, n_reg_writes);
    if (n_errors == 0 && expected_rsps.size() == 0) begin
      $display("tb: success");
    end else begin
      if (expected_rsps.size() != 0)
        $display("%0d expected results never arrived", expected_rsps.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/satc_pkg.sv
hw/rtl/satc_ram.sv
hw/rtl/set_assoc_translation_cache_unit.sv
tb/set_assoc_translation_cache_unit_tb.sv
